### sv/line_buffer_plane_manager_defines.svh
// Assertion macros for the line buffer plane manager
`ifndef LINE_BUFFER_PLANE_MANAGER_DEFINES_SVH
`define LINE_BUFFER_PLANE_MANAGER_DEFINES_SVH
`ifndef SYNTHESIS
`define LBPM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define LBPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define LBPM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define LBPM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### sv/lbpm_pkg.sv
`default_nettype none
package lbpm_pkg;
  localparam int MaxLines   = 256;
  localparam int MaxRows    = 128;
  localparam int PlaneCount = 2;
  localparam int IdW   = 8;
  localparam int CntW  = 9;
  localparam int RowW  = 7;
  localparam int PlW   = 1;
  localparam int EntAw = PlW + RowW;
  localparam int StkAw = 8;

  typedef enum logic [2:0] {
    OP_INIT = 3'd0, OP_ALLOC = 3'd1, OP_FREE = 3'd2, OP_COMMIT = 3'd3,
    OP_PEEK = 3'd4, OP_MOVE = 3'd5, OP_FINISH = 3'd6, OP_FLIP = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0, ST_NOT_READY = 2'd1, ST_OVERFLOW = 2'd2
  } status_t;

  localparam logic CFG_LINE_COUNT   = 1'b0;
  localparam logic CFG_PLANE_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_INIT, S_FLIP_RD, S_FLIP_WR, S_OUT
  } state_t;

  typedef struct packed {
    logic [2:0]      operation;
    logic [IdW-1:0]  line_ref;
    logic [RowW-1:0] row;
  } in_word_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [IdW-1:0]  line_id;
    logic            line_present;
    logic [CntW-1:0] free_lines;
  } out_word_t;

  // memory port bundles
  typedef struct packed {
    logic             we;
    logic [StkAw-1:0] waddr;
    logic [IdW-1:0]   wdata;
    logic [StkAw-1:0] raddr;
  } stk_req_t;

  typedef struct packed {
    logic             we;
    logic [EntAw-1:0] waddr;
    logic [IdW:0]     wdata;   // {taken, id}
    logic [EntAw-1:0] raddr;
  } ent_req_t;
endpackage
`default_nettype wire

### sv/lbpm_stack_mem.sv
`default_nettype none
module lbpm_stack_mem (
  input  wire logic                     clk,
  input  wire lbpm_pkg::stk_req_t       req,
  output logic [lbpm_pkg::IdW-1:0]      rdata
);
  import lbpm_pkg::*;
  logic [IdW-1:0] mem [MaxLines];
  always_ff @(posedge clk) begin
    if (req.we) mem[req.waddr] <= req.wdata;
    rdata <= mem[req.raddr];
  end
endmodule
`default_nettype wire

### sv/lbpm_entry_mem.sv
`default_nettype none
module lbpm_entry_mem (
  input  wire logic                     clk,
  input  wire lbpm_pkg::ent_req_t       req,
  output logic [lbpm_pkg::IdW:0]        rdata
);
  import lbpm_pkg::*;
  logic [IdW:0] mem [PlaneCount*MaxRows];
  always_ff @(posedge clk) begin
    if (req.we) mem[req.waddr] <= req.wdata;
    rdata <= mem[req.raddr];
  end
endmodule
`default_nettype wire

### sv/line_buffer_plane_manager.sv
// line_buffer_plane_manager
// Hands out line buffer IDs from a LIFO free stack and keeps two planes of
// committed IDs with a taken mark per entry.
// Channels: in_ (operation word), out_ (one result word per operation),
// cfg_ (register writes: index 0 line_count, 1 plane_height; always ready).
// All handshakes are valid/stall or valid/ready, taken on rising clk edges.
// One operation at a time, from one accepted word to the next:
//   free, commit, finish: result valid the cycle after accept.
//   allocate, peek, move: one registered memory read first.
//   init: one stack entry a cycle, min(line_count,256) entries in all.
//   flip: per filled row of the read plane, read, then push.
// The stack and entry memories each have one write and one registered read port.
// A result is held in the output register while out_stall is high; the
// next word is accepted once that register empties (in_stall follows busy).
// Reset (rst_n low, synchronous) clears free count, fills and plane indices
// and sets line_count 256, plane_height 128; stack starts empty, memories uncleared.
`default_nettype none
`include "line_buffer_plane_manager_defines.svh"
module line_buffer_plane_manager (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire lbpm_pkg::in_word_t    in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output lbpm_pkg::out_word_t        out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic                  cfg_index,
  input  wire logic [8:0]            cfg_data
);
  import lbpm_pkg::*;

  state_t state_r, state_nxt;
  logic [CntW-1:0] line_count_r;
  logic [7:0]      plane_height_r;
  logic [CntW-1:0] free_count_r, free_count_nxt;
  logic [RowW:0]   fill_r [PlaneCount];
  logic [RowW:0]   fill_nxt [PlaneCount];
  logic [PlW-1:0]  wpl_r, wpl_nxt, rpl_r, rpl_nxt;
  in_word_t        cmd_r, cmd_nxt;
  out_word_t       res_r, res_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;     // init / flip walk index
  logic            flip_ovf_r, flip_ovf_nxt;
  logic [IdW:0]    flip_ent_r, flip_ent_nxt;

  stk_req_t        stk_req;
  ent_req_t        ent_req;
  logic [IdW-1:0]  stk_rdata;
  logic [IdW:0]    ent_rdata;

  lbpm_stack_mem u_stk (.clk(clk), .req(stk_req), .rdata(stk_rdata));
  lbpm_entry_mem u_ent (.clk(clk), .req(ent_req), .rdata(ent_rdata));

  logic            in_acc;
  logic [CntW-1:0] init_n;
  logic [RowW:0]   cap;
  logic [RowW:0]   rfill;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (state_r == S_OUT);
  assign out_data  = res_r;
  assign init_n    = (line_count_r > CntW'(MaxLines)) ? CntW'(MaxLines) : line_count_r;
  assign cap       = (plane_height_r > 8'(MaxRows)) ? (RowW+1)'(MaxRows)
                                                    : (RowW+1)'(plane_height_r);
  assign rfill     = fill_r[rpl_r];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_acc) begin
        case (op_t'(in_data.operation))
          OP_INIT: state_nxt = S_INIT;
          OP_ALLOC, OP_PEEK, OP_MOVE: state_nxt = S_READ;
          OP_FLIP: state_nxt = S_FLIP_RD;
          default: state_nxt = S_OUT;
        endcase
      end
      S_READ:    state_nxt = S_OUT;
      S_INIT:    if (cnt_r + 1'b1 >= init_n) state_nxt = S_OUT;
      S_FLIP_RD: state_nxt = (cnt_r >= CntW'(rfill)) ? S_OUT : S_FLIP_WR;
      S_FLIP_WR: state_nxt = S_FLIP_RD;
      S_OUT:     if (!out_stall) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory requests
  always_comb begin
    logic [CntW-1:0] fc;
    fc = free_count_r;
    free_count_nxt = free_count_r;
    fill_nxt = fill_r;
    wpl_nxt = wpl_r;
    rpl_nxt = rpl_r;
    cmd_nxt = cmd_r;
    res_nxt = res_r;
    cnt_nxt = cnt_r;
    flip_ovf_nxt = flip_ovf_r;
    flip_ent_nxt = flip_ent_r;
    stk_req = '0;
    ent_req = '0;
    case (state_r)
      S_IDLE: if (in_acc) begin
        cmd_nxt = in_data;
        res_nxt = '0;
        cnt_nxt = '0;
        flip_ovf_nxt = 1'b0;
        case (op_t'(in_data.operation))
          OP_INIT: begin
            stk_req.we = (init_n != '0);
            stk_req.waddr = '0;
            stk_req.wdata = '0;
            free_count_nxt = init_n;
            for (int p = 0; p < PlaneCount; p++) fill_nxt[p] = '0;
            res_nxt.free_lines = init_n;
            if (init_n <= CntW'(1)) res_nxt.free_lines = init_n;
          end
          OP_ALLOC: begin
            stk_req.raddr = StkAw'(fc - 1'b1);
            if (fc == '0) res_nxt.status = ST_NOT_READY;
            else free_count_nxt = fc - 1'b1;
            res_nxt.free_lines = free_count_nxt;
          end
          OP_FREE: begin
            if (fc >= CntW'(MaxLines)) res_nxt.status = ST_OVERFLOW;
            else begin
              stk_req.we = 1'b1;
              stk_req.waddr = StkAw'(fc);
              stk_req.wdata = in_data.line_ref;
              free_count_nxt = fc + 1'b1;
            end
            res_nxt.free_lines = free_count_nxt;
          end
          OP_COMMIT: begin
            if (fill_r[wpl_r] >= cap) res_nxt.status = ST_OVERFLOW;
            else begin
              ent_req.we = 1'b1;
              ent_req.waddr = {wpl_r, fill_r[wpl_r][RowW-1:0]};
              ent_req.wdata = {1'b0, in_data.line_ref};
              fill_nxt[wpl_r] = fill_r[wpl_r] + 1'b1;
            end
            res_nxt.free_lines = fc;
          end
          OP_PEEK, OP_MOVE: begin
            ent_req.raddr = {rpl_r, in_data.row};
            res_nxt.free_lines = fc;
          end
          OP_FINISH: begin
            wpl_nxt = wpl_r + 1'b1;
            if (fill_r[wpl_nxt] != '0) res_nxt.status = ST_OVERFLOW;
            res_nxt.free_lines = fc;
          end
          default: begin
            ent_req.raddr = {rpl_r, RowW'(0)};
          end
        endcase
      end
      S_READ: begin
        if (op_t'(cmd_r.operation) == OP_ALLOC) begin
          if (res_r.status == ST_DONE) res_nxt.line_id = stk_rdata;
        end else if ({1'b0, cmd_r.row} >= rfill) begin
          res_nxt.status = ST_NOT_READY;
        end else if (!ent_rdata[IdW]) begin
          res_nxt.line_id = ent_rdata[IdW-1:0];
          res_nxt.line_present = 1'b1;
          if (op_t'(cmd_r.operation) == OP_MOVE) begin
            ent_req.we = 1'b1;
            ent_req.waddr = {rpl_r, cmd_r.row};
            ent_req.wdata = {1'b1, ent_rdata[IdW-1:0]};
          end
        end
      end
      S_INIT: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_nxt < init_n) begin
          stk_req.we = 1'b1;
          stk_req.waddr = StkAw'(cnt_nxt);
          stk_req.wdata = IdW'(cnt_nxt);
        end
      end
      S_FLIP_RD: begin
        // entry at cnt_r was read last cycle
        flip_ent_nxt = ent_rdata;
        if (cnt_r >= CntW'(rfill)) begin
          fill_nxt[rpl_r] = '0;
          rpl_nxt = rpl_r + 1'b1;
          res_nxt.status = flip_ovf_r ? ST_OVERFLOW : ST_DONE;
          res_nxt.free_lines = fc;
        end
      end
      S_FLIP_WR: begin
        if (!flip_ent_r[IdW]) begin
          if (fc >= CntW'(MaxLines)) flip_ovf_nxt = 1'b1;
          else begin
            stk_req.we = 1'b1;
            stk_req.waddr = StkAw'(fc);
            stk_req.wdata = flip_ent_r[IdW-1:0];
            free_count_nxt = fc + 1'b1;
          end
        end
        cnt_nxt = cnt_r + 1'b1;
        ent_req.raddr = {rpl_r, cnt_nxt[RowW-1:0]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      line_count_r   <= CntW'(256);
      plane_height_r <= 8'd128;
      free_count_r   <= '0;
      for (int p = 0; p < PlaneCount; p++) fill_r[p] <= '0;
      wpl_r          <= '0;
      rpl_r          <= '0;
      cnt_r          <= '0;
      flip_ovf_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      free_count_r <= free_count_nxt;
      fill_r       <= fill_nxt;
      wpl_r        <= wpl_nxt;
      rpl_r        <= rpl_nxt;
      cnt_r        <= cnt_nxt;
      flip_ovf_r   <= flip_ovf_nxt;
      if (cfg_valid) begin
        if (cfg_index == CFG_LINE_COUNT) line_count_r <= cfg_data;
        else plane_height_r <= cfg_data[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    res_r      <= res_nxt;
    flip_ent_r <= flip_ent_nxt;
  end

  // checks
  `LBPM_ASSERT_IMPL(a_free_bound, clk, rst_n, 1'b1, free_count_r <= CntW'(MaxLines))
  `LBPM_ASSERT_IMPL(a_busy_stall, clk, rst_n, state_r != S_IDLE, in_stall)
  `LBPM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
  `LBPM_ASSERT_IMPL(a_fill_bound, clk, rst_n, 1'b1, fill_r[wpl_r] <= (RowW+1)'(MaxRows))
endmodule
`default_nettype wire

### dv/tb.sv
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import lbpm_pkg::*;

  // Clock, reset and the three channels
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [8:0] cfg_data = '0;

  line_buffer_plane_manager i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Shadow copy of the manager: stack, planes with taken marks, indices
  logic [8:0] shd_line_count = 9'd256;
  logic [7:0] shd_plane_height = 8'd128;
  logic [IdW-1:0] shd_stack [MaxLines];
  int unsigned shd_free = 0;
  logic [IdW-1:0] shd_entry [PlaneCount][MaxRows];
  bit shd_taken [PlaneCount][MaxRows];
  int unsigned shd_fill [PlaneCount] = '{0, 0};
  int unsigned shd_wr_pl = 0;
  int unsigned shd_rd_pl = 0;

  out_word_t pending_words [$];
  int n_errors = 0;
  int n_results = 0;
  int n_items = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_on = 1'b0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("tb: result %0d %s got %0d want %0d", n_results, what, got, want);
    n_errors++;
  endtask

  function automatic bit push_line(input logic [IdW-1:0] id);
    if (shd_free >= MaxLines) return 1'b0;
    shd_stack[shd_free] = id;
    shd_free++;
    return 1'b1;
  endfunction

  // Work out the result of one operation word and update the shadow copy
  function automatic out_word_t predict_word(input in_word_t w);
    out_word_t r;
    int unsigned lim, f, cap;
    r = '0;
    r.status = ST_DONE;
    case (op_t'(w.operation))
      OP_INIT: begin
        lim = (shd_line_count < MaxLines) ? shd_line_count : MaxLines;
        for (int i = 0; i < lim; i++) shd_stack[i] = i[IdW-1:0];
        shd_free = lim;
        for (int p = 0; p < PlaneCount; p++) shd_fill[p] = 0;
      end
      OP_ALLOC: begin
        if (shd_free == 0) r.status = ST_NOT_READY;
        else begin
          shd_free--;
          r.line_id = shd_stack[shd_free];
        end
      end
      OP_FREE: if (!push_line(w.line_ref)) r.status = ST_OVERFLOW;
      OP_COMMIT: begin
        f = shd_fill[shd_wr_pl];
        cap = (shd_plane_height < MaxRows) ? shd_plane_height : MaxRows;
        if (f >= cap) r.status = ST_OVERFLOW;
        else begin
          shd_entry[shd_wr_pl][f] = w.line_ref;
          shd_taken[shd_wr_pl][f] = 1'b0;
          shd_fill[shd_wr_pl] = f + 1;
        end
      end
      OP_PEEK, OP_MOVE: begin
        if (w.row >= shd_fill[shd_rd_pl]) r.status = ST_NOT_READY;
        else if (!shd_taken[shd_rd_pl][w.row]) begin
          r.line_id = shd_entry[shd_rd_pl][w.row];
          r.line_present = 1'b1;
          if (op_t'(w.operation) == OP_MOVE) shd_taken[shd_rd_pl][w.row] = 1'b1;
        end
      end
      OP_FINISH: begin
        shd_wr_pl = (shd_wr_pl + 1) % PlaneCount;
        if (shd_fill[shd_wr_pl] != 0) r.status = ST_OVERFLOW;
      end
      default: begin
        for (int i = 0; i < shd_fill[shd_rd_pl]; i++)
          if (!shd_taken[shd_rd_pl][i])
            if (!push_line(shd_entry[shd_rd_pl][i])) r.status = ST_OVERFLOW;
        shd_fill[shd_rd_pl] = 0;
        shd_rd_pl = (shd_rd_pl + 1) % PlaneCount;
      end
    endcase
    r.free_lines = shd_free[CntW-1:0];
    return r;
  endfunction

  // Offer one word; the expectation is logged when the block takes it.
  // Valid stays up after the accept until the next word or an idle cycle.
  task automatic send_word(input op_t op, input int ref_id, input int row_sel);
    in_word_t w;
    w.operation = op;
    w.line_ref = ref_id[IdW-1:0];
    w.row = row_sel[RowW-1:0];
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    pending_words = {pending_words, predict_word(w)};
    n_items++;
  endtask

  task automatic write_reg(input logic idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[8:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_LINE_COUNT) shd_line_count = val[8:0];
    else shd_plane_height = val[7:0];
    @(posedge clk);
  endtask

  // Drain, then allow for the longest walk (init or flip) before a write
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
      end else begin
        out_word_t want;
        want = pending_words.pop_front();
        if (out_data.status !== want.status)
          report_mismatch("status", out_data.status, want.status);
        if (out_data.line_id !== want.line_id)
          report_mismatch("line_id", out_data.line_id, want.line_id);
        if (out_data.line_present !== want.line_present)
          report_mismatch("line_present", out_data.line_present, want.line_present);
        if (out_data.free_lines !== want.free_lines)
          report_mismatch("free_lines", out_data.free_lines, want.free_lines);
      end
      n_results++;
    end
  end

  // Receiver stall pattern
  always @(posedge clk) begin
    out_stall <= hold_on || ($urandom_range(99) < recv_stall_pct);
  end

  // Producer/consumer cycle: allocate, commit, finish, read rows, flip
  task automatic run_frame(input int rows);
    for (int i = 0; i < rows; i++) begin
      send_word(OP_ALLOC, $urandom_range(255), $urandom_range(127));
      send_word(OP_COMMIT, $urandom_range(255), 0);
    end
    send_word(OP_FINISH, $urandom_range(255), $urandom_range(127));
    for (int i = 0; i < rows; i++)
      send_word($urandom_range(1) ? OP_MOVE : OP_PEEK, $urandom_range(255),
                $urandom_range(rows));
    send_word(OP_FLIP, $urandom_range(255), $urandom_range(127));
  endtask

  task automatic test_directed();
    send_word(OP_ALLOC, 0, 0);     // empty stack before any init
    send_word(OP_PEEK, 255, 127);  // past the fill
    send_word(OP_INIT, 0, 0);
    send_word(OP_FREE, 8'hAA, 0);  // stack full: dropped
    send_word(OP_ALLOC, 0, 0);
    send_word(OP_COMMIT, 8'hFF, 0);
    send_word(OP_COMMIT, 8'h00, 0);
    send_word(OP_FINISH, 0, 0);
    send_word(OP_PEEK, 0, 0);
    send_word(OP_MOVE, 0, 1);
    send_word(OP_MOVE, 0, 1);      // already taken
    send_word(OP_PEEK, 0, 1);
    send_word(OP_MOVE, 0, 2);
    send_word(OP_FLIP, 0, 0);      // 0xFF goes back onto the stack
    send_word(OP_FINISH, 0, 0);
    send_word(OP_FLIP, 0, 0);
    send_word(OP_COMMIT, 8'h55, 0);
    send_word(OP_FINISH, 0, 0);    // onto an empty plane
    send_word(OP_FREE, 8'h12, 0);
    settle();
  endtask

  task automatic test_small_config();
    write_reg(CFG_LINE_COUNT, 1);
    write_reg(CFG_PLANE_HEIGHT, 0); // height 0: every commit overflows
    send_word(OP_INIT, 0, 0);
    send_word(OP_COMMIT, 3, 0);
    send_word(OP_ALLOC, 0, 0);
    send_word(OP_ALLOC, 0, 0);
    send_word(OP_FREE, 0, 0);
    settle();
    write_reg(CFG_LINE_COUNT, 511); // clipped to 256
    write_reg(CFG_PLANE_HEIGHT, 255); // clipped to 128 rows
    send_word(OP_INIT, 0, 0);
    settle();
  endtask

  task automatic test_random(input int n, input int lc, input int ph);
    write_reg(CFG_LINE_COUNT, lc);
    write_reg(CFG_PLANE_HEIGHT, ph);
    send_word(OP_INIT, 0, 0);
    while (n > 0) begin
      if ($urandom_range(9) < 7) begin
        int rows;
        rows = $urandom_range(1, (ph < 12) ? ph + 1 : 12);
        run_frame(rows);
        n -= 3 * rows + 2;
      end else begin
        op_t op;
        op = op_t'($urandom_range(1, 7));
        send_word(op, $urandom_range(255), $urandom_range(127));
        n--;
      end
    end
    settle();
  endtask

  // Receiver holds off for a long stretch while items keep coming
  task automatic test_backpressure();
    fork
      begin
        hold_on <= 1'b1;
        repeat (300) @(posedge clk);
        hold_on <= 1'b0;
      end
    join_none
    for (int i = 0; i < 20; i++) send_word(OP_ALLOC, 0, 0);
    settle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_small_config();
    test_random(400, 256, 128);
    send_idle_pct = 58;
    test_random(300, 40, 8);
    send_idle_pct = 0;
    recv_stall_pct = 58;
    test_random(300, 200, 1);
    send_idle_pct = 9;
    recv_stall_pct = 9;
    test_random(300, 1, 128);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random(300, 130, 20);
    test_backpressure();
    $display("tb: %0d words sent, %0d results checked", n_items, n_results);
    $display("tb: covered init, alloc, free, commit, peek, move, finish, flip");
    if (n_errors == 0 && pending_words.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb: done, errors");
    $finish;
  end
endmodule
`default_nettype wire
